// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top RTL file of the trail stamp resampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define TSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/tsr_pkg.sv -----
// Types and constants shared by the trail stamp resampler modules.
`default_nettype none
package tsr_pkg;

    localparam int unsigned POS_W    = 20;
    localparam int unsigned DIFF_W   = 21;
    localparam int unsigned DIST_W   = 19;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned ANG_W    = 15;
    localparam int unsigned STEPS_W  = 7;
    localparam int unsigned QDIV_N   = 6;
    localparam int unsigned SQRT_N   = 21;
    localparam int unsigned FRAC_N   = 22;
    localparam int unsigned CORDIC_N = 16;
    localparam int unsigned ITER_W   = 5;
    localparam int unsigned ZW       = 20;
    localparam int unsigned CW       = 44;

    localparam logic [0:0] REG_MIN_DIST  = 1'b0;
    localparam logic [0:0] REG_MAX_COUNT = 1'b1;

    localparam logic signed [ZW-1:0]    PI_Q16  = 20'sd205887;
    localparam logic signed [ANG_W-1:0] ANG_LIM = 15'sd12868;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CMP,
        ST_SQRT,
        ST_QINIT,
        ST_QDIV,
        ST_FINIT,
        ST_FRAC,
        ST_FIX,
        ST_EMIT,
        ST_FIRST
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              mul;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              qdiv_init;
        logic              qdiv_step;
        logic              frac_init;
        logic              frac_step;
        logic              fix;
        logic              emit;
        logic              first;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic draw;
        logic cnt_zero;
        logic too_short;
        logic emit_last;
        logic out_free;
    } sts_t;

    function automatic logic [ZW-1:0] atan_q16(input logic [3:0] i);
        logic [ZW-1:0] v;
        case (i)
            4'd0:    v = 20'd51472;
            4'd1:    v = 20'd30386;
            4'd2:    v = 20'd16055;
            4'd3:    v = 20'd8150;
            4'd4:    v = 20'd4091;
            4'd5:    v = 20'd2047;
            4'd6:    v = 20'd1024;
            4'd7:    v = 20'd512;
            4'd8:    v = 20'd256;
            4'd9:    v = 20'd128;
            4'd10:   v = 20'd64;
            4'd11:   v = 20'd32;
            4'd12:   v = 20'd16;
            4'd13:   v = 20'd8;
            4'd14:   v = 20'd4;
            4'd15:   v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/trail_stamp_resampler.sv -----
// A move goes through decide and compare before its phases; a first point goes from decide to its stamp.
// A move runs square root (21), step divide (6), fraction divide and CORDIC (22) in turn.
// Then one stamp per cycle while the output side takes them.
// Ignored requests go back to idle from decide or compare; one request is in work at a time.
// Synchronous active-low reset empties the trail and loads spacing 16, trim length 100.
`default_nettype none
`include "assert_macros.svh"
module trail_stamp_resampler
    import tsr_pkg::*;
#(
    parameter int unsigned MAX_STEPS = 64
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [0:0]              cfg_addr,
    input  wire logic [DIST_W-1:0]       cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_draw,
    input  wire logic                    s_trim_enable,
    input  wire logic signed [POS_W-1:0] s_pos_x,
    input  wire logic signed [POS_W-1:0] s_pos_y,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [POS_W-1:0]      m_stamp_x,
    output logic signed [POS_W-1:0]      m_stamp_y,
    output logic signed [ANG_W-1:0]      m_stamp_angle,
    output logic [CNT_W-1:0]             m_trail_length,
    output logic                         m_last_of_run
);

    cmd_t cmd;
    sts_t sts;

    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsr_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_draw         (s_draw),
        .s_trim_enable  (s_trim_enable),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_stamp_x      (m_stamp_x),
        .m_stamp_y      (m_stamp_y),
        .m_stamp_angle  (m_stamp_angle),
        .m_trail_length (m_trail_length),
        .m_last_of_run  (m_last_of_run),
        .cmd            (cmd),
        .sts            (sts)
    );

    `TSR_ASSERT_NXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready)
    `TSR_ASSERT_IMP(a_emit_slot, aclk, aresetn, cmd.emit || cmd.first, !m_valid || m_ready)
    `TSR_ASSERT_IMP(a_emit_idle, aclk, aresetn, cmd.emit || cmd.first, !s_ready)

endmodule
`default_nettype wire

// ----- hw/rtl/tsr_ctrl.sv -----
// Sequencer of the trail stamp resampler: walks one request through its phases.
`default_nettype none
module tsr_ctrl
    import tsr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (!sts.draw)         state_next = ST_IDLE;
                else if (sts.cnt_zero) state_next = ST_FIRST;
                else                   state_next = ST_CMP;
            end
            ST_CMP:    state_next = sts.too_short ? ST_IDLE : ST_SQRT;
            ST_SQRT:   if (iter_reg == ITER_W'(SQRT_N - 1)) state_next = ST_QINIT;
            ST_QINIT:  state_next = ST_QDIV;
            ST_QDIV:   if (iter_reg == ITER_W'(QDIV_N - 1)) state_next = ST_FINIT;
            ST_FINIT:  state_next = ST_FRAC;
            ST_FRAC:   if (iter_reg == ITER_W'(FRAC_N - 1)) state_next = ST_FIX;
            ST_FIX:    state_next = ST_EMIT;
            ST_EMIT:   if (sts.out_free && sts.emit_last) state_next = ST_IDLE;
            ST_FIRST:  if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // restart the iteration count on every phase change
    always_comb begin
        iter_next = (state_next != state_reg) ? '0 : iter_reg + 1'b1;
    end

    always_comb begin
        cmd      = '0;
        cmd.iter = iter_reg;
        s_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_DECIDE: cmd.mul       = 1'b1;
            ST_CMP:    cmd.sqrt_init = 1'b1;
            ST_SQRT:   cmd.sqrt_step = 1'b1;
            ST_QINIT:  cmd.qdiv_init = 1'b1;
            ST_QDIV:   cmd.qdiv_step = 1'b1;
            ST_FINIT:  cmd.frac_init = 1'b1;
            ST_FRAC:   cmd.frac_step = 1'b1;
            ST_FIX:    cmd.fix       = 1'b1;
            ST_EMIT:   cmd.emit      = sts.out_free;
            ST_FIRST:  cmd.first     = sts.out_free;
            default:   cmd.iter      = iter_reg;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tsr_dp.sv -----
// Datapath of the trail stamp resampler: trail state, square root, dividers, CORDIC, output.
`default_nettype none
module tsr_dp
    import tsr_pkg::*;
#(
    parameter int unsigned MAX_STEPS = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [0:0]               cfg_addr,
    input  wire logic [DIST_W-1:0]        cfg_wdata,
    input  wire logic                     s_draw,
    input  wire logic                     s_trim_enable,
    input  wire logic signed [POS_W-1:0]  s_pos_x,
    input  wire logic signed [POS_W-1:0]  s_pos_y,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [POS_W-1:0]       m_stamp_x,
    output logic signed [POS_W-1:0]       m_stamp_y,
    output logic signed [ANG_W-1:0]       m_stamp_angle,
    output logic [CNT_W-1:0]              m_trail_length,
    output logic                          m_last_of_run,
    input  wire cmd_t                     cmd,
    output sts_t                          sts
);

    localparam logic [STEPS_W-1:0] STEP_CAP = STEPS_W'(MAX_STEPS);
    localparam int unsigned DW = STEPS_W + 1;

    // configuration and trail state
    logic [DIST_W-1:0]       min_dist_reg;
    logic [CNT_W-1:0]        max_cnt_reg;
    logic signed [POS_W-1:0] last_x_reg, last_y_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    was_draw_reg;

    // request working set
    logic                     draw_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [2*DIFF_W-2:0]      sqx_reg, sqy_reg;
    logic [2*DIST_W-1:0]      mm_reg;

    logic [2*DIFF_W-1:0]      src_reg;
    logic [SQRT_N+1:0]        srem_reg;
    logic [SQRT_N-1:0]        root_reg;

    logic [DIST_W+QDIV_N-1:0] qrem_reg;
    logic [QDIV_N-1:0]        q_reg;
    logic                     cap_reg;

    logic [STEPS_W-1:0]       steps_reg;
    logic [DW-1:0]            den_reg;
    logic [FRAC_N-1:0]        nx_reg, ny_reg;
    logic [DW-1:0]            rx_reg, ry_reg;
    logic                     negx_reg, negy_reg;

    logic signed [FRAC_N:0]   qx_reg, qy_reg;
    logic [DW-1:0]            fx_reg, fy_reg;
    logic signed [FRAC_N:0]   ax_reg, ay_reg;
    logic [DW-1:0]            ex_reg, ey_reg;
    logic [STEPS_W-1:0]       em_idx_reg;

    logic signed [CW-1:0]     cx_reg, cy_reg;
    logic signed [ZW-1:0]     cz_reg;
    logic signed [ANG_W-1:0]  ang_reg;

    logic                     m_valid_reg;
    logic signed [POS_W-1:0]  ox_reg, oy_reg;
    logic signed [ANG_W-1:0]  oang_reg;
    logic [CNT_W-1:0]         olen_reg;
    logic                     olast_reg;

    // combinational helpers
    logic [DIST_W-1:0]        meff;
    logic [CNT_W-1:0]         cnt_trim, cnt_sat;
    logic [2*DIFF_W-1:0]      s_sum;
    logic [SQRT_N+3:0]        sq_ext, sq_trial;
    logic [DIST_W+QDIV_N-1:0] m_sh;
    logic [STEPS_W-1:0]       steps_n;
    logic [FRAC_N-1:0]        magx, magy;
    logic [DW:0]              tx, ty;
    logic [3:0]               ci;
    logic signed [CW-1:0]     xs, ys;
    logic signed [CW-1:0]     x0, y0;
    logic signed [ZW-1:0]     zr, za;
    logic [DW:0]              rsx, rsy;
    logic                     carx, cary;
    logic [DW-1:0]            rnx, rny;
    logic signed [FRAC_N:0]   anx, any;

    assign meff    = (min_dist_reg == '0) ? DIST_W'(1) : min_dist_reg;
    assign cnt_sat = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    always_comb begin
        cnt_trim = (s_trim_enable && cnt_reg > max_cnt_reg) ? max_cnt_reg : cnt_reg;
        if (was_draw_reg && !s_draw) cnt_trim = '0;
    end

    assign s_sum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign sq_ext   = {srem_reg, src_reg[2*DIFF_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign m_sh     = (DIST_W+QDIV_N)'(meff) << (QDIV_N - 1 - int'(cmd.iter));

    always_comb begin
        if (cap_reg || {1'b0, q_reg} > STEP_CAP) steps_n = STEP_CAP;
        else                                      steps_n = STEPS_W'(q_reg);
    end

    assign magx = {(dx_reg[DIFF_W-1] ? (FRAC_N-1)'(-dx_reg) : (FRAC_N-1)'(dx_reg)), 1'b0};
    assign magy = {(dy_reg[DIFF_W-1] ? (FRAC_N-1)'(-dy_reg) : (FRAC_N-1)'(dy_reg)), 1'b0};
    assign tx   = {rx_reg, nx_reg[FRAC_N-1]};
    assign ty   = {ry_reg, ny_reg[FRAC_N-1]};

    assign ci = cmd.iter[3:0];
    assign xs = cx_reg >>> ci;
    assign ys = cy_reg >>> ci;
    assign x0 = {{(CW-DIFF_W-20){dx_reg[DIFF_W-1]}}, dx_reg, 20'b0};
    assign y0 = {{(CW-DIFF_W-20){dy_reg[DIFF_W-1]}}, dy_reg, 20'b0};
    assign zr = cz_reg + ZW'(8);
    assign za = zr >>> 4;

    // next stamp: advance fraction, carry into the position accumulator
    assign rsx  = {1'b0, ex_reg} + {1'b0, fx_reg};
    assign rsy  = {1'b0, ey_reg} + {1'b0, fy_reg};
    assign carx = rsx >= {1'b0, den_reg};
    assign cary = rsy >= {1'b0, den_reg};
    assign rnx  = carx ? DW'(rsx - {1'b0, den_reg}) : DW'(rsx);
    assign rny  = cary ? DW'(rsy - {1'b0, den_reg}) : DW'(rsy);
    assign anx  = ax_reg + qx_reg + (FRAC_N+1)'(carx);
    assign any  = ay_reg + qy_reg + (FRAC_N+1)'(cary);

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.accept)                 cnt_next = cnt_trim;
        else if (cmd.first)             cnt_next = CNT_W'(1);
        else if (cmd.emit)              cnt_next = cnt_sat;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg <= DIST_W'(16);
            max_cnt_reg  <= CNT_W'(100);
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            cnt_reg      <= '0;
            was_draw_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MIN_DIST:  min_dist_reg <= cfg_wdata;
                    REG_MAX_COUNT: max_cnt_reg  <= cfg_wdata[CNT_W-1:0];
                    default:       min_dist_reg <= min_dist_reg;
                endcase
            end
            cnt_reg <= cnt_next;
            if (cmd.accept) was_draw_reg <= s_draw;
            if (cmd.first || (cmd.emit && sts.emit_last)) begin
                last_x_reg <= px_reg;
                last_y_reg <= py_reg;
            end
            if (cmd.first || cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready)          m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            draw_reg <= s_draw;
            px_reg   <= s_pos_x;
            py_reg   <= s_pos_y;
            dx_reg   <= DIFF_W'(s_pos_x) - DIFF_W'(last_x_reg);
            dy_reg   <= DIFF_W'(s_pos_y) - DIFF_W'(last_y_reg);
        end
        if (cmd.mul) begin
            sqx_reg <= (2*DIFF_W-1)'(dx_reg * dx_reg);
            sqy_reg <= (2*DIFF_W-1)'(dy_reg * dy_reg);
            mm_reg  <= meff * meff;
        end
        if (cmd.sqrt_init) begin
            src_reg  <= s_sum;
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            src_reg <= src_reg << 2;
            if (sq_ext >= sq_trial) begin
                srem_reg <= (SQRT_N+2)'(sq_ext - sq_trial);
                root_reg <= {root_reg[SQRT_N-2:0], 1'b1};
            end else begin
                srem_reg <= sq_ext[SQRT_N+1:0];
                root_reg <= {root_reg[SQRT_N-2:0], 1'b0};
            end
        end
        if (cmd.qdiv_init) begin
            cap_reg  <= (DIST_W+QDIV_N+1)'(root_reg) >= ((DIST_W+QDIV_N+1)'(meff) << QDIV_N);
            qrem_reg <= (DIST_W+QDIV_N)'(root_reg);
            q_reg    <= '0;
        end else if (cmd.qdiv_step) begin
            if (!cap_reg && qrem_reg >= m_sh) begin
                qrem_reg <= qrem_reg - m_sh;
                q_reg    <= {q_reg[QDIV_N-2:0], 1'b1};
            end else begin
                q_reg    <= {q_reg[QDIV_N-2:0], 1'b0};
            end
        end
        if (cmd.frac_init) begin
            steps_reg  <= steps_n;
            den_reg    <= {steps_n, 1'b0};
            em_idx_reg <= STEPS_W'(1);
            nx_reg     <= magx;
            ny_reg     <= magy;
            rx_reg     <= '0;
            ry_reg     <= '0;
            negx_reg   <= dx_reg[DIFF_W-1];
            negy_reg   <= dy_reg[DIFF_W-1];
            if (dx_reg[DIFF_W-1]) begin
                cx_reg <= -x0;
                cy_reg <= -y0;
                cz_reg <= dy_reg[DIFF_W-1] ? -PI_Q16 : PI_Q16;
            end else begin
                cx_reg <= x0;
                cy_reg <= y0;
                cz_reg <= '0;
            end
        end else if (cmd.frac_step) begin
            if (tx >= {1'b0, den_reg}) begin
                rx_reg <= DW'(tx - {1'b0, den_reg});
                nx_reg <= {nx_reg[FRAC_N-2:0], 1'b1};
            end else begin
                rx_reg <= tx[DW-1:0];
                nx_reg <= {nx_reg[FRAC_N-2:0], 1'b0};
            end
            if (ty >= {1'b0, den_reg}) begin
                ry_reg <= DW'(ty - {1'b0, den_reg});
                ny_reg <= {ny_reg[FRAC_N-2:0], 1'b1};
            end else begin
                ry_reg <= ty[DW-1:0];
                ny_reg <= {ny_reg[FRAC_N-2:0], 1'b0};
            end
            if (cmd.iter < ITER_W'(CORDIC_N)) begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + signed'(atan_q16(ci));
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - signed'(atan_q16(ci));
                end
            end
        end
        if (cmd.fix) begin
            // floor division of a negative numerator
            if (negx_reg && rx_reg != '0) begin
                qx_reg <= -((FRAC_N+1)'(nx_reg) + 1'b1);
                fx_reg <= den_reg - rx_reg;
            end else begin
                qx_reg <= negx_reg ? -(FRAC_N+1)'(nx_reg) : (FRAC_N+1)'(nx_reg);
                fx_reg <= negx_reg ? '0 : rx_reg;
            end
            if (negy_reg && ry_reg != '0) begin
                qy_reg <= -((FRAC_N+1)'(ny_reg) + 1'b1);
                fy_reg <= den_reg - ry_reg;
            end else begin
                qy_reg <= negy_reg ? -(FRAC_N+1)'(ny_reg) : (FRAC_N+1)'(ny_reg);
                fy_reg <= negy_reg ? '0 : ry_reg;
            end
            ax_reg <= (FRAC_N+1)'(last_x_reg);
            ay_reg <= (FRAC_N+1)'(last_y_reg);
            ex_reg <= DW'(steps_reg);
            ey_reg <= DW'(steps_reg);
            if (za > ZW'(ANG_LIM))       ang_reg <= ANG_LIM;
            else if (za < -ZW'(ANG_LIM)) ang_reg <= -ANG_LIM;
            else                         ang_reg <= za[ANG_W-1:0];
        end
        if (cmd.emit) begin
            ax_reg     <= anx;
            ay_reg     <= any;
            ex_reg     <= rnx;
            ey_reg     <= rny;
            em_idx_reg <= em_idx_reg + 1'b1;
            ox_reg     <= anx[POS_W-1:0];
            oy_reg     <= any[POS_W-1:0];
            oang_reg   <= ang_reg;
            olen_reg   <= cnt_sat;
            olast_reg  <= sts.emit_last;
        end else if (cmd.first) begin
            ox_reg    <= px_reg;
            oy_reg    <= py_reg;
            oang_reg  <= '0;
            olen_reg  <= CNT_W'(1);
            olast_reg <= 1'b1;
        end
    end

    assign sts.draw      = draw_reg;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.too_short = s_sum < (2*DIFF_W)'(mm_reg);
    assign sts.emit_last = (em_idx_reg == steps_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_stamp_x      = ox_reg;
    assign m_stamp_y      = oy_reg;
    assign m_stamp_angle  = oang_reg;
    assign m_trail_length = olen_reg;
    assign m_last_of_run  = olast_reg;

endmodule
`default_nettype wire
